// File: rtl/core/audio_waveshaper_unit_assert.svh
// Assertion macros used by the waveshaper top level.
`ifndef AUDIO_WAVESHAPER_UNIT_ASSERT_SVH
`define AUDIO_WAVESHAPER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define AWU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("waveshaper check failed");

// Next-cycle implication, checked out of reset.
`define AWU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("waveshaper check failed");

`endif

// File: rtl/core/awu_pkg.sv
package awu_pkg;

    typedef enum logic [1:0] {
        SHP_SINE    = 2'd0,
        SHP_ATAN    = 2'd1,
        SHP_SIGMOID = 2'd2,
        SHP_CUBIC   = 2'd3
    } shape_t;

    typedef enum logic [2:0] {
        REG_SHAPE     = 3'd0,
        REG_STRENGTH  = 3'd1,
        REG_INV_STR   = 3'd2,
        REG_SIG_GAIN  = 3'd3,
        REG_POLY_GAIN = 3'd4
    } reg_idx_t;

    localparam logic [63:0] ONE62      = 64'h4000_0000_0000_0000;
    localparam logic [63:0] INV_TWO_PI = 64'h28BE_60DB_9391_054A;
    localparam logic [63:0] HALF_PI    = 64'h6487_ED51_10B4_611A;
    localparam logic [63:0] QUARTER_PI = 64'h3243_F6A8_885A_308D;

    localparam int NUM_OPS = 94;

    typedef struct packed {
        logic [32:0] strength;
        logic [31:0] inv_strength;
        logic [31:0] sigmoid_gain;
        logic [31:0] poly_gain;
    } cfg_t;

    typedef struct packed {
        shape_t      shape;
        logic        sign;
        logic        recip;
        logic        fold;
        logic        big;
        logic [6:0]  dcnt;
        logic [5:0]  n;
        logic [63:0] p;
        logic [63:0] t;
        logic [63:0] term;
        logic [63:0] x2;
        logic [63:0] pos;
        logic [63:0] nacc;
        logic [63:0] val;
        logic [63:0] e;
        logic [63:0] r;
        logic [63:0] rem;
        logic [63:0] dlo;
        logic [63:0] den;
        logic [63:0] quo;
        logic [63:0] pp00;
        logic [63:0] pp01;
        logic [63:0] pp10;
        logic [63:0] pp11;
    } item_t;

    function automatic logic [63:0] mul_shr62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] f;
        f = {64'd0, a} * {64'd0, b};
        if (f[127:126] != 2'd0)
            return '1;
        return f[125:62];
    endfunction

    // exp(-1) as the truncated 25-term series, worked out at elaboration
    function automatic logic [63:0] exp_neg_one();
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        term = ONE62;
        pos  = ONE62;
        neg  = 64'd0;
        for (int k = 1; k <= 24; k++)
        begin
            term = mul_shr62(term, ONE62) / 64'(k);
            if ((k % 2) == 1)
                neg = neg + term;
            else
                pos = pos + term;
        end
        return (pos > neg) ? (pos - neg) : 64'd0;
    endfunction

    localparam logic [63:0] EXP_NEG_ONE = exp_neg_one();

endpackage

// File: rtl/core/awu_stage.sv
module awu_stage #(
    parameter int SAMPLE_BITS = 24,
    parameter int OP          = 0,
    parameter int PH          = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  awu_pkg::cfg_t  cfg,
    input  logic           vin,
    input  awu_pkg::item_t din,
    output logic           vout,
    output awu_pkg::item_t dout
);

    localparam int FRAC = SAMPLE_BITS + 15;
    localparam int RSH  = 79 - SAMPLE_BITS;
    localparam logic [63:0] ONE_A = 64'd1 << FRAC;

    localparam bit SIN_MUL = (OP <= 15) || (OP == 17);
    localparam bit ATN_MUL = ((OP >= 47) && (OP <= 78)) || (OP == 81);
    localparam bit ATN_DIV = ((OP >= 1) && (OP <= 22)) || ((OP >= 24) && (OP <= 45));
    localparam bit SIG_MUL = ((OP >= 1) && (OP <= 24)) || ((OP >= 26) && (OP <= 69))
                             || (OP == 93);
    localparam bit SIG_DIV = (OP >= 71) && (OP <= 92);
    localparam bit CUB_MUL = OP <= 2;

    localparam int SinK = OP - 2;
    localparam int AtnK = OP - 47;
    localparam logic [63:0] SinDiv = ((OP >= 3) && (OP <= 15)) ?
                                     64'((2 * SinK) * (2 * SinK + 1)) : 64'd1;
    localparam logic [63:0] AtnDiv = ((OP >= 48) && (OP <= 78)) ? 64'(2 * AtnK + 1) : 64'd1;
    localparam logic [63:0] SigDiv = ((OP >= 1) && (OP <= 24)) ? 64'(OP) : 64'd1;
    localparam bit SIN_ODD = (SinK % 2) == 1;
    localparam bit ATN_ODD = (AtnK % 2) == 1;
    localparam bit SIG_ODD = (OP % 2) == 1;
    localparam logic [6:0] SigJ = 7'(OP - 25);

    logic           valid_reg;
    awu_pkg::item_t item_reg;
    awu_pkg::item_t item_next;

    logic [63:0]  opa;
    logic [63:0]  opb;
    logic [6:0]   sh;
    logic         rnd;
    logic         wide;
    logic         is_mul;
    logic         is_div;
    logic [127:0] full;
    logic [128:0] rsum;
    logic [128:0] rshift;
    logic         carry;
    logic [63:0]  rem2;
    logic [63:0]  tmp;
    logic [63:0]  tt;
    logic [63:0]  quot;

    always_comb
    begin
        opa    = 64'd0;
        opb    = 64'd0;
        sh     = 7'd62;
        rnd    = 1'b0;
        wide   = 1'b0;
        is_mul = 1'b0;
        is_div = 1'b0;
        case (din.shape)
            awu_pkg::SHP_SINE:
            begin
                is_mul = SIN_MUL;
                if (OP == 0)
                begin
                    opa  = din.p;
                    opb  = awu_pkg::INV_TWO_PI;
                    wide = 1'b1;
                end
                else if (OP == 1)
                begin
                    opa = din.t;
                    opb = awu_pkg::HALF_PI;
                end
                else if (OP == 2)
                begin
                    opa = din.term;
                    opb = din.term;
                end
                else if (OP == 17)
                begin
                    opa = din.val;
                    opb = 64'(cfg.inv_strength);
                    sh  = 7'(RSH);
                    rnd = 1'b1;
                end
                else
                begin
                    opa = din.term;
                    opb = din.x2;
                end
            end
            awu_pkg::SHP_ATAN:
            begin
                is_mul = ATN_MUL;
                is_div = ATN_DIV;
                if (OP == 47)
                begin
                    opa = din.t;
                    opb = din.t;
                end
                else if (OP == 81)
                begin
                    opa = din.val;
                    opb = 64'(cfg.inv_strength);
                    sh  = 7'(RSH);
                    rnd = 1'b1;
                end
                else
                begin
                    opa = din.term;
                    opb = din.x2;
                end
            end
            awu_pkg::SHP_SIGMOID:
            begin
                is_mul = SIG_MUL;
                is_div = SIG_DIV;
                if (OP <= 24)
                begin
                    opa = din.term;
                    opb = din.t;
                end
                else if (OP == 93)
                begin
                    opa = din.quo;
                    opb = 64'(cfg.sigmoid_gain);
                    sh  = 7'(RSH);
                    rnd = 1'b1;
                end
                else
                begin
                    opa = din.e;
                    opb = awu_pkg::EXP_NEG_ONE;
                end
            end
            awu_pkg::SHP_CUBIC:
            begin
                is_mul = CUB_MUL;
                if (OP == 2)
                begin
                    opa = din.t;
                    opb = 64'(cfg.poly_gain);
                    sh  = 7'd32;
                    rnd = 1'b1;
                end
                else
                begin
                    opa = (OP == 0) ? din.p : din.t;
                    opb = din.p;
                    sh  = 7'(FRAC);
                end
            end
            default:
            begin
                is_mul = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        item_next = din;
        full      = {64'd0, din.pp00} + ({64'd0, din.pp01} << 32)
                    + ({64'd0, din.pp10} << 32) + {din.pp11, 64'd0};
        rsum      = {1'b0, full} + (rnd ? (129'd1 << (sh - 7'd1)) : 129'd0);
        rshift    = rsum >> sh;
        carry     = din.rem[63];
        rem2      = {din.rem[62:0], din.dlo[63]};
        tmp       = 64'd0;
        tt        = 64'd0;
        quot      = 64'd0;

        if (is_div && (din.dcnt != 7'd0))
        begin
            // one quotient bit per stage
            item_next.dlo  = {din.dlo[62:0], 1'b0};
            item_next.dcnt = din.dcnt - 7'd1;
            if (carry || (rem2 >= din.den))
            begin
                item_next.rem = rem2 - din.den;
                item_next.quo = {din.quo[62:0], 1'b1};
            end
            else
            begin
                item_next.rem = rem2;
                item_next.quo = {din.quo[62:0], 1'b0};
            end
        end
        else if (is_mul && (PH == 0))
        begin
            item_next.pp00 = 64'(opa[31:0])  * 64'(opb[31:0]);
            item_next.pp01 = 64'(opa[31:0])  * 64'(opb[63:32]);
            item_next.pp10 = 64'(opa[63:32]) * 64'(opb[31:0]);
            item_next.pp11 = 64'(opa[63:32]) * 64'(opb[63:32]);
        end
        else if (is_mul && (PH == 1))
        begin
            if (wide)
                item_next.r = full[FRAC+63:FRAC];
            else if (rshift[128:64] != 65'd0)
                item_next.r = '1;
            else
                item_next.r = rshift[63:0];
        end

        if (PH == 2)
        begin
            case (din.shape)
                awu_pkg::SHP_SINE:
                begin
                    if (OP == 0)
                    begin
                        // fold the turn into one quadrant
                        tmp = {2'b00, din.r[61:0]};
                        if (din.r[62])
                            tmp = awu_pkg::ONE62 - tmp;
                        item_next.t = tmp;
                        if (din.r[63])
                            item_next.sign = ~din.sign;
                    end
                    else if (OP == 1)
                    begin
                        item_next.term = din.r;
                        item_next.pos  = din.r;
                        item_next.nacc = 64'd0;
                    end
                    else if (OP == 2)
                    begin
                        item_next.x2 = din.r;
                    end
                    else if ((OP >= 3) && (OP <= 15))
                    begin
                        quot           = din.r / SinDiv;
                        item_next.term = quot;
                        if (SIN_ODD)
                            item_next.nacc = din.nacc + quot;
                        else
                            item_next.pos = din.pos + quot;
                    end
                    else if (OP == 16)
                    begin
                        item_next.val = (din.pos > din.nacc) ? (din.pos - din.nacc) : 64'd0;
                    end
                end
                awu_pkg::SHP_ATAN:
                begin
                    if (OP == 0)
                    begin
                        item_next.recip = din.p > ONE_A;
                        item_next.fold  = 1'b0;
                        item_next.t     = din.p << (62 - FRAC);
                        item_next.rem   = 64'd1 << (FRAC - 2);
                        item_next.dlo   = 64'd0;
                        item_next.den   = din.p;
                        item_next.quo   = 64'd0;
                        item_next.dcnt  = (din.p > ONE_A) ? 7'd64 : 7'd0;
                    end
                    else if (OP == 23)
                    begin
                        tt             = din.recip ? din.quo : din.t;
                        tmp            = awu_pkg::ONE62 - tt;
                        item_next.t    = tt;
                        item_next.fold = tt > (awu_pkg::ONE62 >> 1);
                        item_next.rem  = tmp >> 2;
                        item_next.dlo  = tmp << 62;
                        item_next.den  = awu_pkg::ONE62 + tt;
                        item_next.quo  = 64'd0;
                        item_next.dcnt = (tt > (awu_pkg::ONE62 >> 1)) ? 7'd64 : 7'd0;
                    end
                    else if (OP == 46)
                    begin
                        if (din.fold)
                            item_next.t = din.quo;
                    end
                    else if (OP == 47)
                    begin
                        item_next.x2   = din.r;
                        item_next.term = din.t;
                        item_next.pos  = din.t;
                        item_next.nacc = 64'd0;
                    end
                    else if ((OP >= 48) && (OP <= 78))
                    begin
                        quot           = din.r / AtnDiv;
                        item_next.term = din.r;
                        if (ATN_ODD)
                            item_next.nacc = din.nacc + quot;
                        else
                            item_next.pos = din.pos + quot;
                    end
                    else if (OP == 79)
                    begin
                        tmp = (din.pos > din.nacc) ? (din.pos - din.nacc) : 64'd0;
                        item_next.val = din.fold ? (awu_pkg::QUARTER_PI - tmp) : tmp;
                    end
                    else if (OP == 80)
                    begin
                        if (din.recip)
                            item_next.val = awu_pkg::HALF_PI - din.val;
                    end
                end
                awu_pkg::SHP_SIGMOID:
                begin
                    if (OP == 0)
                    begin
                        // split 5a into whole part and fraction
                        tmp            = (din.p * 64'd5) << (58 - FRAC);
                        item_next.big  = !(din.p < (ONE_A * 64'd9));
                        item_next.n    = tmp[63:58];
                        item_next.t    = {tmp[57:0], 4'b0000};
                        item_next.term = awu_pkg::ONE62;
                        item_next.pos  = awu_pkg::ONE62;
                        item_next.nacc = 64'd0;
                    end
                    else if ((OP >= 1) && (OP <= 24))
                    begin
                        quot           = din.r / SigDiv;
                        item_next.term = quot;
                        if (SIG_ODD)
                            item_next.nacc = din.nacc + quot;
                        else
                            item_next.pos = din.pos + quot;
                    end
                    else if (OP == 25)
                    begin
                        item_next.e = (din.pos > din.nacc) ? (din.pos - din.nacc) : 64'd0;
                    end
                    else if ((OP >= 26) && (OP <= 69))
                    begin
                        if (!din.big && (SigJ <= {1'b0, din.n}))
                            item_next.e = din.r;
                    end
                    else if (OP == 70)
                    begin
                        tt = din.big ? 64'd0 : din.e;
                        if (tt > awu_pkg::ONE62)
                            tt = awu_pkg::ONE62;
                        tmp            = awu_pkg::ONE62 - tt;
                        item_next.rem  = tmp >> 2;
                        item_next.dlo  = tmp << 62;
                        item_next.den  = awu_pkg::ONE62 + tt;
                        item_next.quo  = 64'd0;
                        item_next.dcnt = 7'd64;
                    end
                end
                awu_pkg::SHP_CUBIC:
                begin
                    if (OP == 0)
                    begin
                        item_next.t = din.r;
                    end
                    else if (OP == 1)
                    begin
                        tmp         = din.p + din.r;
                        item_next.t = (tmp < din.p) ? '1 : tmp;
                    end
                end
                default:
                begin
                    item_next.t = din.t;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign vout = valid_reg;
    assign dout = item_reg;

endmodule

// File: rtl/core/audio_waveshaper_unit.sv
// An input transfer reaches its result on the master side through two front stages,
// 94 three-stage operation slots and one output register. Throughput: one sample per
// cycle unless the master side stalls; the series and divider steps are fully unrolled.
// A stall on the master side holds every stage at once; nothing is dropped or repeated.
// Reset clears all valid bits and loads the register defaults (strength 1.0).
`include "audio_waveshaper_unit_assert.svh"

module audio_waveshaper_unit #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // sample_in
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,   // sample_out
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [5:0]                          paddr,
    input  logic [63:0]                         pwdata,
    output logic [63:0]                         prdata,
    output logic                                pready
);

    localparam int TDW  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int NSTG = awu_pkg::NUM_OPS * 3;
    localparam logic [63:0] HALF = 64'd1 << (SAMPLE_BITS - 1);

    awu_pkg::shape_t shape_reg;
    logic [32:0]     strength_reg;
    logic [31:0]     inv_strength_reg;
    logic [31:0]     sigmoid_gain_reg;
    logic [31:0]     poly_gain_reg;
    awu_pkg::cfg_t   cfg;
    logic            cfg_wr;
    awu_pkg::reg_idx_t cfg_idx;

    logic                   en;
    logic [SAMPLE_BITS-1:0] sample;
    logic [SAMPLE_BITS-1:0] mag;
    awu_pkg::item_t         front_next;
    logic                   front_valid_reg;
    awu_pkg::item_t         front_item_reg;
    awu_pkg::item_t         drive_next;

    logic                   st_valid [NSTG+1];
    awu_pkg::item_t         st_item  [NSTG+1];

    logic [63:0]            rr;
    logic [SAMPLE_BITS-1:0] out_next;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_sample_reg;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = awu_pkg::reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg        <= awu_pkg::SHP_SINE;
            strength_reg     <= 33'd65536;
            inv_strength_reg <= 32'd65536;
            sigmoid_gain_reg <= 32'd66425;
            poly_gain_reg    <= 32'd32768;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                awu_pkg::REG_SHAPE:     shape_reg        <= awu_pkg::shape_t'(pwdata[1:0]);
                awu_pkg::REG_STRENGTH:  strength_reg     <= pwdata[32:0];
                awu_pkg::REG_INV_STR:   inv_strength_reg <= pwdata[31:0];
                awu_pkg::REG_SIG_GAIN:  sigmoid_gain_reg <= pwdata[31:0];
                awu_pkg::REG_POLY_GAIN: poly_gain_reg    <= pwdata[31:0];
                default:                shape_reg        <= shape_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            awu_pkg::REG_SHAPE:     prdata = 64'(shape_reg);
            awu_pkg::REG_STRENGTH:  prdata = 64'(strength_reg);
            awu_pkg::REG_INV_STR:   prdata = 64'(inv_strength_reg);
            awu_pkg::REG_SIG_GAIN:  prdata = 64'(sigmoid_gain_reg);
            awu_pkg::REG_POLY_GAIN: prdata = 64'(poly_gain_reg);
            default:                prdata = 64'd0;
        endcase
    end

    assign cfg.strength     = strength_reg;
    assign cfg.inv_strength = inv_strength_reg;
    assign cfg.sigmoid_gain = sigmoid_gain_reg;
    assign cfg.poly_gain    = poly_gain_reg;

    // one global advance: the output register frees or is taken
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // front stage: sign and magnitude
    assign sample = s_tdata[SAMPLE_BITS-1:0];
    assign mag    = sample[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - sample) : sample;

    always_comb
    begin
        front_next       = '0;
        front_next.shape = shape_reg;
        front_next.sign  = sample[SAMPLE_BITS-1];
        front_next.p     = 64'(mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else if (en)
            front_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            front_item_reg <= front_next;
    end

    // drive stage: p = |x| * strength
    always_comb
    begin
        drive_next   = front_item_reg;
        drive_next.p = 64'(front_item_reg.p[SAMPLE_BITS-1:0]) * 64'(strength_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_valid[0] <= 1'b0;
        else if (en)
            st_valid[0] <= front_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            st_item[0] <= drive_next;
    end

    for (genvar g = 0; g < NSTG; g++)
    begin : g_stage
        awu_stage #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .OP          (g / 3),
            .PH          (g % 3)
        ) u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .cfg   (cfg),
            .vin   (st_valid[g]),
            .din   (st_item[g]),
            .vout  (st_valid[g+1]),
            .dout  (st_item[g+1])
        );
    end

    // saturate and restore sign
    always_comb
    begin
        if (st_item[NSTG].sign)
        begin
            rr       = (st_item[NSTG].r > HALF) ? HALF : st_item[NSTG].r;
            out_next = SAMPLE_BITS'(64'd0 - rr);
        end
        else
        begin
            rr       = (st_item[NSTG].r > (HALF - 64'd1)) ? (HALF - 64'd1) : st_item[NSTG].r;
            out_next = rr[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= st_valid[NSTG];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_sample_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDW'(out_sample_reg);

    `AWU_ASSERT_NOW(a_div_done, st_valid[NSTG], st_item[NSTG].dcnt == 7'd0)
    `AWU_ASSERT_NOW(a_zero_drive, m_tvalid && (strength_reg == 33'd0), out_sample_reg == '0)
    `AWU_ASSERT_NOW(a_zero_poly, m_tvalid && (shape_reg == awu_pkg::SHP_CUBIC) && (poly_gain_reg == 32'd0), out_sample_reg == '0)

endmodule
